// ----- hdl/pns_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pns_pkg: shared types and constants
// Field types, sequencer states and fixed-point constants for the polyline
// nearest-segment block.
// ----------------------------------------------------------------------------
package pns_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned SegW   = 4;
  localparam int unsigned TOne   = 65536;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               cmd;
    logic               restart_path;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               suffix_last;
    logic               path_empty;
    logic [3:0]         nearest_segment;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_DIFF,
    ST_MUL,
    ST_TSET,
    ST_DIV,
    ST_PROJ,
    ST_DIST,
    ST_CMP,
    ST_EMIT,
    ST_EMRD,
    ST_OUT
  } state_e;
endpackage
`default_nettype wire

// ----- hdl/pns_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pns_if: valid/ready channel
// Carries one word of a generic payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface pns_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/pns_mac.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pns_mac: shared multiply unit
// One registered 34x34 signed multiply; the sequencer selects its operands.
// ----------------------------------------------------------------------------
module pns_mac (
  input  wire logic               clk_i,
  input  wire logic signed [33:0] a_i,
  input  wire logic signed [33:0] b_i,
  output logic signed [67:0]      p_o
);
  logic signed [67:0] p_q;
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end
  assign p_o = p_q;
endmodule
`default_nettype wire

// ----- hdl/polyline_nearest_segment_suffix.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_nearest_segment_suffix: nearest segment and path suffix
// Stores a waypoint path and answers position queries with the path suffix.
// ----------------------------------------------------------------------------
// Usage: in_i takes append and query words; out_o returns result words.
// An append is stored at its accepting edge and produces nothing; in_i
// stays ready. An append to a full path without restart_path is dropped.
// A query with N >= 2 waypoints walks N-1 segments through one shared
// registered multiplier and a one-bit-per-cycle divider: it loads a
// segment, forms the squared length and dot product terms, runs the
// quotient only when the projection falls inside the segment, then forms
// the projected point and the distance and does the compare.
// It then emits the position and every later waypoint, with one memory
// read for each waypoint. A query with one waypoint or with none walks no
// segment. in_i is not ready while a query runs or a word waits. A stalled
// out_o holds the word and the sequencer until it is taken. Reset empties
// the path; the waypoint memory itself is not cleared.
// ----------------------------------------------------------------------------
module polyline_nearest_segment_suffix #(
  parameter int unsigned MAX_WAYPOINTS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pns_if.sink       in_i,
  pns_if.source     out_o
);
  import pns_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_WAYPOINTS);
  localparam int unsigned CntW = $clog2(MAX_WAYPOINTS + 1);

  logic [95:0] mem_q [MAX_WAYPOINTS];
  logic [95:0] rd_q;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] cnt_q;

  state_e state_q, state_d;
  logic signed [31:0] p_q [3];
  logic signed [31:0] a_q [3];
  logic signed [33:0] ab_q [3];
  logic signed [33:0] ap_q [3];
  logic signed [69:0] len2_q, dot_q, d2_q, best_q;
  logic signed [69:0] dot_sum;
  logic [IdxW-1:0] seg_q, best_seg_q;
  logic [CntW-1:0] emi_q;
  logic [16:0] t_q;
  logic [4:0] step_q;
  logic [1:0] ax_q;
  logic mul_pipe_q;
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  out_word_t ow_q;
  logic ov_q;

  pns_mac u_mac (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(prod));

  function automatic logic signed [33:0] crd(input logic [95:0] w, input logic [1:0] k);
    case (k)
      2'd0:    crd = 34'(signed'(w[95:64]));
      2'd1:    crd = 34'(signed'(w[63:32]));
      default: crd = 34'(signed'(w[31:0]));
    endcase
  endfunction

  wire in_fire = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE) && !ov_q;
  assign out_o.valid = ov_q;
  assign out_o.data = ow_q;

  // full dot product once the last term leaves the multiplier
  assign dot_sum = dot_q + 70'(prod);

  // memory port: write on append, one registered read
  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.data.cmd == CMD_APPEND) begin
      if (in_i.data.restart_path)
        mem_q[0] <= {in_i.data.pos_x, in_i.data.pos_y, in_i.data.pos_z};
      else if (cnt_q < CntW'(MAX_WAYPOINTS))
        mem_q[cnt_q[IdxW-1:0]] <= {in_i.data.pos_x, in_i.data.pos_y, in_i.data.pos_z};
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    rd_addr = seg_q;
    if (state_q == ST_RDB) rd_addr = IdxW'(seg_q + 1'b1);
    if (state_q == ST_EMIT || state_q == ST_EMRD || state_q == ST_OUT) rd_addr = emi_q[IdxW-1:0];
    if (state_q == ST_IDLE) rd_addr = '0;
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      ST_MUL: begin
        ma = ab_q[ax_q];
        mb = step_q[0] ? ap_q[ax_q] : ab_q[ax_q];
      end
      ST_PROJ: begin
        if (ax_q != 2'd3) begin
          ma = 34'(t_q);
          mb = ab_q[ax_q];
        end
      end
      ST_DIST: begin
        ma = ap_q[ax_q];
        mb = ap_q[ax_q];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire && in_i.data.cmd == CMD_QUERY) begin
        if (cnt_q > CntW'(1)) state_d = ST_RDA;
        else if (cnt_q == CntW'(1)) state_d = ST_EMRD;
      end
      ST_RDA:  state_d = ST_RDB;
      ST_RDB:  state_d = ST_DIFF;
      ST_DIFF: state_d = ST_MUL;
      ST_MUL:  if (ax_q == 2'd2 && step_q[0] && mul_pipe_q) state_d = ST_TSET;
      ST_TSET: state_d = (len2_q != 0 && dot_sum > 0 && dot_sum < len2_q) ? ST_DIV : ST_PROJ;
      ST_DIV:  if (step_q == 5'd15) state_d = ST_PROJ;
      ST_PROJ: if (ax_q == 2'd3) state_d = ST_DIST;
      ST_DIST: if (ax_q == 2'd2 && mul_pipe_q) state_d = ST_CMP;
      ST_CMP:  state_d = (CntW'(seg_q) + CntW'(2) >= cnt_q) ? ST_EMIT : ST_RDA;
      ST_EMIT: if (!ov_q) state_d = (emi_q >= cnt_q) ? ST_IDLE : ST_EMRD;
      ST_EMRD: state_d = ST_OUT;
      ST_OUT:  if (!ov_q) state_d = ST_EMIT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_o.valid && out_o.ready) ov_q <= 1'b0;
      if (in_fire) begin
        if (in_i.data.cmd == CMD_APPEND) begin
          if (in_i.data.restart_path) cnt_q <= CntW'(1);
          else if (cnt_q < CntW'(MAX_WAYPOINTS)) cnt_q <= cnt_q + 1'b1;
        end else if (cnt_q == '0) begin
          ov_q <= 1'b1;
        end
      end
      // the position word goes out on the first pass through emit only
      if (state_q == ST_EMIT && state_d == ST_EMRD && emi_q == '0) ov_q <= 1'b1;
      if (state_q == ST_OUT && !ov_q) ov_q <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        seg_q <= '0;
        best_seg_q <= '0;
        emi_q <= '0;
        p_q[0] <= in_i.data.pos_x;
        p_q[1] <= in_i.data.pos_y;
        p_q[2] <= in_i.data.pos_z;
        if (in_fire && in_i.data.cmd == CMD_QUERY) begin
          ow_q.suffix_last <= 1'b1;
          ow_q.nearest_segment <= '0;
          ow_q.path_empty <= (cnt_q == '0);
          ow_q.out_x <= '0;
          ow_q.out_y <= '0;
          ow_q.out_z <= '0;
        end
      end
      ST_RDB: begin
        a_q[0] <= rd_q[95:64];
        a_q[1] <= rd_q[63:32];
        a_q[2] <= rd_q[31:0];
        for (int k = 0; k < 3; k++) ap_q[k] <= 34'(p_q[k]) - crd(rd_q, 2'(k));
      end
      ST_DIFF: begin
        // rd_q now holds the far end of the segment
        for (int k = 0; k < 3; k++) ab_q[k] <= crd(rd_q, 2'(k)) - 34'(a_q[k]);
        len2_q <= '0;
        dot_q <= '0;
        ax_q <= '0;
        step_q <= '0;
        mul_pipe_q <= 1'b0;
      end
      ST_MUL: begin
        // alternate: even step issues ab*ab, odd step issues ab*ap
        mul_pipe_q <= 1'b1;
        if (mul_pipe_q) begin
          if (step_q[0]) len2_q <= len2_q + 70'(prod);
          else dot_q <= dot_q + 70'(prod);
        end
        step_q <= step_q + 1'b1;
        if (step_q[0]) ax_q <= ax_q + 1'b1;
      end
      ST_TSET: begin
        dot_q <= dot_sum;
        ax_q <= '0;
        step_q <= '0;
        mul_pipe_q <= 1'b0;
        if (len2_q == 0 || dot_sum <= 0) t_q <= '0;
        else if (dot_sum >= len2_q) t_q <= 17'(TOne);
        else t_q <= '0;
      end
      ST_DIV: begin
        if ((dot_q <<< 1) >= len2_q) begin
          dot_q <= (dot_q <<< 1) - len2_q;
          t_q <= {t_q[15:0], 1'b1};
        end else begin
          dot_q <= dot_q <<< 1;
          t_q <= {t_q[15:0], 1'b0};
        end
        step_q <= step_q + 1'b1;
      end
      ST_PROJ: begin
        // the product of the previous axis lands in the cycle after it is issued
        if (ax_q != 2'd0) ap_q[ax_q - 2'd1] <= ap_q[ax_q - 2'd1] - 34'(prod >>> 16);
        if (ax_q == 2'd3) begin
          ax_q <= '0;
          d2_q <= '0;
        end else begin
          ax_q <= ax_q + 1'b1;
        end
      end
      ST_DIST: begin
        mul_pipe_q <= 1'b1;
        if (mul_pipe_q) d2_q <= d2_q + 70'(prod);
        if (ax_q != 2'd2 || !mul_pipe_q) ax_q <= ax_q + 1'b1;
      end
      ST_CMP: begin
        if (seg_q == '0 || d2_q + 70'(prod) < best_q) begin
          best_q <= d2_q + 70'(prod);
          best_seg_q <= seg_q;
        end
        seg_q <= seg_q + 1'b1;
        emi_q <= '0;
      end
      ST_EMIT: begin
        if (!ov_q) begin
          if (emi_q == '0) begin
            ow_q.out_x <= p_q[0];
            ow_q.out_y <= p_q[1];
            ow_q.out_z <= p_q[2];
            ow_q.path_empty <= 1'b0;
            ow_q.nearest_segment <= 4'(best_seg_q);
            emi_q <= CntW'(best_seg_q) + CntW'(1);
            ow_q.suffix_last <= (CntW'(best_seg_q) + CntW'(1) >= cnt_q);
          end
        end
      end
      ST_OUT: begin
        if (!ov_q) begin
          ow_q.out_x <= rd_q[95:64];
          ow_q.out_y <= rd_q[63:32];
          ow_q.out_z <= rd_q[31:0];
          ow_q.suffix_last <= (emi_q + CntW'(1) >= cnt_q);
          emi_q <= emi_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_i.ready) else $error("ready while busy");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_WAYPOINTS)) else $error("count overflow");
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && ow_q.path_empty |-> ow_q.suffix_last) else $error("empty not last");
`endif
endmodule
`default_nettype wire
